>>> rtl/mrpt_pkg.sv
package mrpt_pkg;

  // Index of the last of the twelve fixed witnesses.
  localparam logic [3:0] WIT_LAST = 4'd11;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIAL,
    S_SPLIT,
    S_WINIT,
    S_PSTEP,
    S_WACC,
    S_PSQR,
    S_WB,
    S_CHECK,
    S_SQLOOP,
    S_WSQ,
    S_NEXTW,
    S_DONE
  } mrpt_state_t;

  // Status reported by the trial division unit.
  typedef struct packed {
    logic done;
    logic eq_any;
    logic div_any;
  } mrpt_trial_t;

  // The witnesses are the first twelve primes.
  function automatic logic [5:0] mrpt_witness(input logic [3:0] idx);
    logic [5:0] w;
    unique case (idx)
      4'd0:    w = 6'd2;
      4'd1:    w = 6'd3;
      4'd2:    w = 6'd5;
      4'd3:    w = 6'd7;
      4'd4:    w = 6'd11;
      4'd5:    w = 6'd13;
      4'd6:    w = 6'd17;
      4'd7:    w = 6'd19;
      4'd8:    w = 6'd23;
      4'd9:    w = 6'd29;
      4'd10:   w = 6'd31;
      4'd11:   w = 6'd37;
      default: w = 6'd2;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/mrpt_trial.sv
module mrpt_trial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [63:0]          number,
  output mrpt_pkg::mrpt_trial_t status
);
  import mrpt_pkg::*;

  logic [63:0] sh_r, sh_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic        eq_r, eq_nxt;
  logic [5:0]  rem_r   [12];
  logic [5:0]  rem_nxt [12];
  logic [11:0] zero_vec;
  logic [11:0] eq_vec;

  // One remainder lane per witness; the number enters one byte per cycle, MSB first.
  // Each byte is folded in by eight short compare-and-subtract steps.
  for (genvar i = 0; i < 12; i++) begin : g_lane
    logic [6:0] t;
    logic [6:0] w7;
    logic [5:0] part;
    always_comb begin
      w7   = {1'b0, mrpt_witness(4'(i))};
      part = rem_r[i];
      t    = '0;
      for (int j = 0; j < 8; j++) begin
        t    = {part, sh_r[63 - j]};
        part = (t >= w7) ? 6'(t - w7) : t[5:0];
      end
      if (go) begin
        rem_nxt[i] = '0;
      end else if (run_r) begin
        rem_nxt[i] = part;
      end else begin
        rem_nxt[i] = rem_r[i];
      end
    end
    assign zero_vec[i] = (rem_r[i] == 6'd0);
    assign eq_vec[i]   = (number == {58'd0, mrpt_witness(4'(i))});
  end

  // Byte counter and control of the serial pass.
  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    eq_nxt   = eq_r;
    if (go) begin
      sh_nxt  = number;
      cnt_nxt = '0;
      run_nxt = 1'b1;
      eq_nxt  = |eq_vec;
    end else if (run_r) begin
      sh_nxt  = {sh_r[55:0], 8'd0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    eq_r  <= eq_nxt;
    for (int k = 0; k < 12; k++) begin
      rem_r[k] <= rem_nxt[k];
    end
  end

  assign status.done    = done_r;
  assign status.eq_any  = eq_r;
  assign status.div_any = |zero_vec;

endmodule

>>> rtl/mrpt_mulmod.sv
module mrpt_mulmod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  input  logic [63:0] modulus,
  output logic        done,
  output logic [63:0] result
);
  import mrpt_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic        run_r, run_nxt;
  logic [64:0] m65;
  logic [64:0] sum_acc;
  logic [64:0] sum_dbl;
  logic [63:0] acc_add;
  logic [63:0] x_dbl;

  // Two modular adds in parallel: acc + x and x + x, both operands below the modulus.
  always_comb begin
    m65     = {1'b0, modulus};
    sum_acc = {1'b0, acc_r} + {1'b0, x_r};
    sum_dbl = {1'b0, x_r} + {1'b0, x_r};
    acc_add = (sum_acc >= m65) ? 64'(sum_acc - m65) : sum_acc[63:0];
    x_dbl   = (sum_dbl >= m65) ? 64'(sum_dbl - m65) : sum_dbl[63:0];
  end

  // One multiplier bit per cycle, LSB first, until the multiplier is exhausted.
  always_comb begin
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    run_nxt = run_r;
    if (go) begin
      acc_nxt = '0;
      x_nxt   = opa;
      y_nxt   = opb;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (y_r == 64'd0) begin
        run_nxt = 1'b0;
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_add;
        end
        x_nxt = x_dbl;
        y_nxt = {1'b0, y_r[63:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done   = run_r && (y_r == 64'd0);
  assign result = acc_r;

endmodule

>>> rtl/miller_rabin_prime_test_64.sv
// Deterministic primality test for unsigned 64-bit numbers.
// Input: drive in_number and raise start while busy is low; the transfer
// happens at that clock edge and busy stays high until the result is out.
// Output: out_valid is high for exactly one cycle with out_is_prime; that
// cycle's closing edge is the transfer, and the receiver cannot stall it.
// The next number may be started in the cycle after out_valid.
// Numbers below 2, equal to a witness, or divisible by one get their result
// straight after the trial division, which takes one byte per cycle.
// Other numbers go through Miller-Rabin with witnesses 2 to 37; each modular
// product runs in the shared shift-and-add multiplier, one doubling step per
// cycle, and a number needs at most 125 of them per witness, about 1500 in
// all.
// One number is handled at a time. Reset returns the sequencer to idle and
// drops any number in progress; nothing is kept between numbers.
module miller_rabin_prime_test_64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_number,
  output logic        out_valid,
  output logic        out_is_prime
);
  import mrpt_pkg::*;

  mrpt_state_t state_r, state_nxt;
  logic [63:0] n_r, n_nxt;
  logic [63:0] d_r, d_nxt;
  logic [5:0]  s_r, s_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] e_r, e_nxt;
  logic [5:0]  r_r, r_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic        prime_r, prime_nxt;
  logic [63:0] nm1;
  logic [63:0] e_half;
  logic        trial_go;
  mrpt_trial_t trial;
  logic        mul_go;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        early_out;

  assign nm1       = n_r - 64'd1;
  assign e_half    = {1'b0, e_r[63:1]};
  assign early_out = (n_r < 64'd2) || trial.eq_any || trial.div_any;

  mrpt_trial u_trial (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (trial_go),
    .number (in_number),
    .status (trial)
  );

  mrpt_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mul_go),
    .opa     (mul_a),
    .opb     (mul_b),
    .modulus (n_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_TRIAL;
      S_TRIAL:  if (trial.done) state_nxt = early_out ? S_DONE : S_SPLIT;
      S_SPLIT:  if (d_r[0]) state_nxt = S_WINIT;
      S_WINIT:  state_nxt = S_PSTEP;
      S_PSTEP: begin
        if (e_r == 64'd0) begin
          state_nxt = S_CHECK;
        end else if (e_r[0]) begin
          state_nxt = S_WACC;
        end else begin
          state_nxt = S_PSQR;
        end
      end
      S_WACC:   if (mul_done) state_nxt = S_PSQR;
      S_PSQR:   state_nxt = (e_half == 64'd0) ? S_CHECK : S_WB;
      S_WB:     if (mul_done) state_nxt = S_PSTEP;
      S_CHECK:  state_nxt = ((acc_r == 64'd1) || (acc_r == nm1)) ? S_NEXTW : S_SQLOOP;
      S_SQLOOP: state_nxt = (r_r < s_r) ? S_WSQ : S_DONE;
      S_WSQ:    if (mul_done) state_nxt = (mul_res == nm1) ? S_NEXTW : S_SQLOOP;
      S_NEXTW:  state_nxt = (widx_r == WIT_LAST) ? S_DONE : S_WINIT;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Unit launches and multiplier operand selection.
  always_comb begin
    trial_go = 1'b0;
    mul_go   = 1'b0;
    mul_a    = acc_r;
    mul_b    = b_r;
    unique case (state_r)
      S_IDLE:   trial_go = start;
      S_PSTEP:  mul_go = (e_r != 64'd0) && e_r[0];
      S_PSQR: begin
        mul_go = (e_half != 64'd0);
        mul_a  = b_r;
        mul_b  = b_r;
      end
      S_SQLOOP: begin
        mul_go = (r_r < s_r);
        mul_a  = acc_r;
        mul_b  = acc_r;
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  // Datapath registers updated by the sequencer.
  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    s_nxt     = s_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    r_nxt     = r_r;
    widx_nxt  = widx_r;
    prime_nxt = prime_r;
    case (state_r)
      S_IDLE: begin
        if (start) n_nxt = in_number;
      end
      S_TRIAL: begin
        d_nxt    = nm1;
        s_nxt    = '0;
        widx_nxt = '0;
        // Below two is not prime; a witness itself is prime; a multiple is not.
        prime_nxt = (n_r >= 64'd2) && trial.eq_any;
      end
      S_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = {1'b0, d_r[63:1]};
          s_nxt = s_r + 6'd1;
        end
      end
      S_WINIT: begin
        acc_nxt = 64'd1;
        b_nxt   = {58'd0, mrpt_witness(widx_r)};
        e_nxt   = d_r;
      end
      S_WACC: begin
        if (mul_done) acc_nxt = mul_res;
      end
      S_PSQR: begin
        e_nxt = e_half;
      end
      S_WB: begin
        if (mul_done) b_nxt = mul_res;
      end
      S_CHECK: begin
        r_nxt = 6'd1;
      end
      S_SQLOOP: begin
        if (r_r >= s_r) prime_nxt = 1'b0;
      end
      S_WSQ: begin
        if (mul_done) begin
          acc_nxt = mul_res;
          r_nxt   = r_r + 6'd1;
        end
      end
      S_NEXTW: begin
        if (widx_r == WIT_LAST) begin
          prime_nxt = 1'b1;
        end else begin
          widx_nxt = widx_r + 4'd1;
        end
      end
      default: begin
        prime_nxt = prime_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    s_r     <= s_nxt;
    acc_r   <= acc_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    r_r     <= r_nxt;
    widx_r  <= widx_nxt;
    prime_r <= prime_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_DONE);
  assign out_is_prime = prime_r;

  // An accepted number keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted number did not make the block busy");

  // The result strobe lasts one cycle.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_WACC) || (state_r == S_WB) || (state_r == S_WSQ))
    else $error("modular product finished outside a wait state");

  // A prime result is odd or is two.
  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_prime |-> n_r[0] || (n_r == 64'd2))
    else $error("even number other than two reported prime");

endmodule

>>> tb/miller_rabin_prime_test_64_tb.sv
module miller_rabin_prime_test_64_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_COUNT    = 79;
  localparam int unsigned DIRECTED_COUNT  = 21;
  localparam int unsigned TOTAL_ITEMS     = DIRECTED_COUNT + RANDOM_COUNT;
  localparam int unsigned CYCLES_PER_ITEM = 160000;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam bit [63:0] WITNESS [12] = '{
    64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
    64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
  };

  // Zero, one, witnesses and their neighbors, squares of primes, strong
  // pseudoprimes to several bases, the largest 64-bit prime and range ends.
  localparam bit [63:0] DIRECTED [DIRECTED_COUNT] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd38, 64'd39, 64'd41,
    64'd561, 64'd1369, 64'd1681, 64'd2021, 64'd1373653, 64'd25326001,
    64'd3215031751, 64'd3825123056546413051, 64'd18446744073709551557,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'd4294967291 * 64'd4294967279
  };

  typedef struct {
    bit [63:0]   number;
    bit          prime;
    int unsigned idle_pct;
  } test_item_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_number;
  logic        out_valid;
  logic        out_is_prime;

  test_item_t      pending_q[$];
  bit              expected_prime_q[$];
  test_item_t      cur_item;
  bit              xfer_seen;
  int unsigned     item_index;
  int unsigned     results_seen;
  int unsigned     err_count;
  longint unsigned cycle_count;
  longint unsigned cycle_limit;

  miller_rabin_prime_test_64 u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  // (a + b) mod m without overflow.
  function automatic bit [63:0] add_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
    bit [63:0] x;
    bit [63:0] y;
    if (m == 64'd0) return 64'd0;
    x = a % m;
    y = b % m;
    if (x >= m - y) return x - (m - y);
    return x + y;
  endfunction

  // (a * b) mod m by doubling and adding.
  function automatic bit [63:0] mul_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
    bit [63:0] acc;
    bit [63:0] x;
    bit [63:0] y;
    acc = 64'd0;
    if (m == 64'd0) return 64'd0;
    x = a % m;
    y = b;
    while (y != 64'd0) begin
      if (y[0]) acc = add_mod(acc, x, m);
      x = add_mod(x, x, m);
      y = y >> 1;
    end
    return acc;
  endfunction

  // (b ^ e) mod m by square and multiply.
  function automatic bit [63:0] pow_mod(bit [63:0] b, bit [63:0] e, bit [63:0] m);
    bit [63:0] acc;
    bit [63:0] base;
    bit [63:0] ex;
    if (m == 64'd0) return 64'd0;
    acc  = 64'd1 % m;
    base = b % m;
    ex   = e;
    while (ex != 64'd0) begin
      if (ex[0]) acc = mul_mod(acc, base, m);
      base = mul_mod(base, base, m);
      ex   = ex >> 1;
    end
    return acc;
  endfunction

  // Exact primality over the whole 64-bit range with the fixed witnesses.
  function automatic bit is_prime_64(bit [63:0] n);
    bit [63:0]   nm1;
    bit [63:0]   d;
    bit [63:0]   x;
    int unsigned s;
    bit          witness_ok;
    if (n < 64'd2) return 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (n == WITNESS[i]) return 1'b1;
      if (n % WITNESS[i] == 64'd0) return 1'b0;
    end
    nm1 = n - 64'd1;
    d   = nm1;
    s   = 0;
    while (!d[0] && d != 64'd0) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < 12; i++) begin
      x = pow_mod(WITNESS[i], d, n);
      if (x == 64'd1 || x == nm1) continue;
      witness_ok = 1'b0;
      for (int unsigned r = 1; r < s; r++) begin
        x = mul_mod(x, x, n);
        if (x == nm1) begin
          witness_ok = 1'b1;
          break;
        end
      end
      if (!witness_ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Random value of the given width, 1 to 64 bits.
  function automatic bit [63:0] rand_bits(int unsigned w);
    bit [63:0] r;
    r = {$urandom, $urandom};
    if (w >= 64) return r;
    return r & ((64'd1 << w) - 64'd1);
  endfunction

  // Queue one number with its predicted answer; the idle rate follows the
  // position of the item in the run.
  task automatic push_number(bit [63:0] n);
    test_item_t item;
    item.number = n;
    item.prime  = is_prime_64(n);
    case ((item_index * 3) / TOTAL_ITEMS)
      0:       item.idle_pct = 26;
      1:       item.idle_pct = 63;
      default: item.idle_pct = 0;
    endcase
    pending_q.push_back(item);
    item_index++;
  endtask

  // Random numbers of mixed shapes. Primes past the witnesses are the slow
  // case, so only a handful of them are let through.
  task automatic fill_random();
    bit [63:0]   n;
    bit [63:0]   a;
    bit [63:0]   b;
    bit          prime;
    bit          coprime;
    int unsigned prime_budget;
    prime_budget = 6;
    for (int unsigned k = 0; k < RANDOM_COUNT; k++) begin
      do begin
        case ($urandom_range(0, 5))
          0: n = {$urandom, $urandom};
          1: n = 64'($urandom_range(0, 4096));
          2: n = {32'd0, $urandom};
          3: begin
            n = rand_bits($urandom_range(6, 64)) | 64'd1;
            coprime = 1'b0;
            while (!coprime) begin
              coprime = 1'b1;
              for (int i = 1; i < 12; i++) begin
                if (n % WITNESS[i] == 64'd0) coprime = 1'b0;
              end
              if (!coprime) n = n + 64'd2;
            end
          end
          4: begin
            a = rand_bits($urandom_range(6, 32)) | 64'd1;
            b = rand_bits($urandom_range(6, 32)) | 64'd1;
            n = a * b;
          end
          default: begin
            if ($urandom_range(0, 1) == 0) begin
              n = WITNESS[$urandom_range(0, 11)] + 64'($urandom_range(0, 2)) - 64'd1;
            end else begin
              n = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100));
            end
          end
        endcase
        prime = is_prime_64(n);
      end while (prime && n > 64'd37 && prime_budget == 0);
      if (prime && n > 64'd37) prime_budget--;
      push_number(n);
    end
  endtask

  // Free-running clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Driver: presents the next number at the falling edge once the previous
  // transfer has happened, idling at random between items.
  always @(negedge clk) begin : drive_blk
    bit        drive_start;
    bit [63:0] drive_number;
    drive_start  = start;
    drive_number = in_number;
    if (rst_n && (!start || xfer_seen)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= pending_q[0].idle_pct) begin
        cur_item     = pending_q.pop_front();
        drive_start  = 1'b1;
        drive_number = cur_item.number;
      end else begin
        drive_start  = 1'b0;
        drive_number = {$urandom, $urandom};
      end
    end
    start     <= drive_start;
    in_number <= drive_number;
  end

  // Monitor: records input transfers and checks each result against the
  // oldest expected answer.
  always @(posedge clk) begin : check_blk
    bit want;
    xfer_seen = rst_n && start && !busy;
    if (xfer_seen) expected_prime_q.push_back(cur_item.prime);
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_prime_q.size() == 0) begin
        if (err_count < MAX_REPORTS) begin
          $display("ERROR: result %0b with no number outstanding", out_is_prime);
        end
        err_count++;
      end else begin
        want = expected_prime_q.pop_front();
        if (out_is_prime !== want) begin
          if (err_count < MAX_REPORTS) begin
            $display("ERROR: is_prime expected %0b got %0b", want, out_is_prime);
          end
          err_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("FAIL miller_rabin_prime_test_64");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_number    = 64'd0;
    xfer_seen    = 1'b0;
    item_index   = 0;
    results_seen = 0;
    err_count    = 0;
    cycle_count  = 0;
    cycle_limit  = 64'(TOTAL_ITEMS) * (CYCLES_PER_ITEM + 200) * 4 + 1000;

    foreach (DIRECTED[i]) push_number(DIRECTED[i]);
    fill_random();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every number yields exactly one result.
    while (results_seen < TOTAL_ITEMS) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (err_count == 0 && expected_prime_q.size() == 0) begin
      $display("PASS miller_rabin_prime_test_64");
    end else begin
      $display("FAIL miller_rabin_prime_test_64");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mrpt_pkg.sv
rtl/mrpt_trial.sv
rtl/mrpt_mulmod.sv
rtl/miller_rabin_prime_test_64.sv
tb/miller_rabin_prime_test_64_tb.sv
